>>> rtl/elp_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Entity lump parser package
// Scanner codes, key text tables and character constants shared by the parser.
// -----------------------------------------------------------------------------
package elp_pkg;

  localparam int unsigned NAME_LEN_DEF = 63;

  localparam int unsigned NUM_W = 32;
  localparam int unsigned NUM_COUNT = 5;
  localparam int unsigned OUT_DATA_W = NUM_COUNT * NUM_W + 8;

  localparam logic [1:0] MODE_OUT = 2'd0;
  localparam logic [1:0] MODE_IN  = 2'd1;
  localparam logic [1:0] MODE_STR = 2'd2;

  localparam logic [2:0] KEY_CLASS  = 3'd0;
  localparam logic [2:0] KEY_ORIGIN = 3'd1;
  localparam logic [2:0] KEY_ANGLE  = 3'd2;
  localparam logic [2:0] KEY_FLAGS  = 3'd3;
  localparam logic [2:0] KEY_NONE   = 3'd4;

  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_POS   = 3'd1;
  localparam logic [2:0] PH_NEG   = 3'd2;
  localparam logic [2:0] PH_PDONE = 3'd3;
  localparam logic [2:0] PH_NDONE = 3'd4;

  localparam int unsigned N_X     = 0;
  localparam int unsigned N_Y     = 1;
  localparam int unsigned N_Z     = 2;
  localparam int unsigned N_ANGLE = 3;
  localparam int unsigned N_FLAGS = 4;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] KEY_LEN [4] = '{8'd9, 8'd6, 8'd5, 8'd10};

  localparam logic [7:0] KEY_TEXT [4][16] = '{
    '{"c", "l", "a", "s", "s", "n", "a", "m", "e", 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "r", "i", "g", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"a", "n", "g", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"s", "p", "a", "w", "n", "f", "l", "a", "g", "s",
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> rtl/elp_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds its data
// while no read is requested.
// -----------------------------------------------------------------------------
module elp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/entity_lump_parser.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Entity lump parser
// Scans entity text one byte at a time and emits each entity's class name
// characters together with its origin, angle and spawn flags.
// -----------------------------------------------------------------------------
// Channel  Direction  Payload                                      Marker
// s_axis   in         text_byte                                    -
// m_axis   out        origin x, y, z, angle, flags, name_char      tlast
//
// Text bytes are taken one per cycle while no name burst is in progress.
// A closing brace starts a burst of the name characters, read from the name RAM
// through its one read port, and a closing zero, one per cycle while the output
// is not stalled; input is held off until the last result leaves the read stage.
// The output register lets a byte be taken while the last result still waits.
// Reset is asynchronous and active low; the name RAM itself is not cleared.
// -----------------------------------------------------------------------------
module entity_lump_parser #(
  parameter int unsigned NAME_LEN = elp_pkg::NAME_LEN_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] text_byte
  input  logic [7:0]                      s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] origin_x, [63:32] origin_y, [95:64] origin_z, [127:96] facing_angle,
  // [159:128] spawn_flags, [167:160] name_char
  output logic [elp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int unsigned LenW  = $clog2(NAME_LEN + 1);
  localparam int unsigned AddrW = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
  localparam logic [LenW-1:0] NameMax = LenW'(NAME_LEN);

  logic [1:0]  mode_q, mode_d;
  logic [2:0]  key_q, key_d;
  logic [3:0]  flags_q, flags_d;
  logic [7:0]  pos_q, pos_d;
  logic [LenW-1:0] nlen_q, nlen_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  phase_q, phase_d;
  logic [1:0]  opart_q, opart_d;
  logic [31:0] nums_q [elp_pkg::NUM_COUNT];
  logic [31:0] nums_d [elp_pkg::NUM_COUNT];
  logic        ended_q, ended_d;

  logic            busy_q, busy_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic            rd_v_q, rd_v_d;
  logic            term_q, term_d;
  logic            out_v_q, out_v_d;
  logic [elp_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic            out_last_q, out_last_d;

  logic            in_acc;
  logic [7:0]      c;
  logic            burst_start;
  logic            load;
  logic            advance;
  logic            issue;
  logic            ram_we;
  logic            ram_re;
  logic [7:0]      ram_rdata;
  logic [31:0]     value;
  logic [31:0]     digit_val;
  logic [7:0]      name_char;

  assign c = s_axis_tdata;
  assign s_axis_tready = !busy_q && !rd_v_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign value = ((phase_q == elp_pkg::PH_NEG) || (phase_q == elp_pkg::PH_NDONE)) ?
                 (32'd0 - acc_q) : acc_q;
  assign digit_val = {24'd0, c - elp_pkg::CH_ZERO};

  always_comb begin
    mode_d  = mode_q;
    key_d   = key_q;
    flags_d = flags_q;
    pos_d   = pos_q;
    nlen_d  = nlen_q;
    acc_d   = acc_q;
    phase_d = phase_q;
    opart_d = opart_q;
    nums_d  = nums_q;
    ended_d = ended_q;
    ram_we  = 1'b0;
    burst_start = 1'b0;
    if (in_acc) begin
      unique case (mode_q)
        elp_pkg::MODE_IN: begin
          if (c == elp_pkg::CH_QUOTE) begin
            mode_d  = elp_pkg::MODE_STR;
            pos_d   = 8'd0;
            flags_d = 4'hf;
            acc_d   = 32'd0;
            phase_d = elp_pkg::PH_SKIP;
            opart_d = 2'd0;
            ended_d = 1'b0;
            if (key_q == elp_pkg::KEY_CLASS) begin
              nlen_d = '0;
            end
            if (key_q == elp_pkg::KEY_ORIGIN) begin
              nums_d[elp_pkg::N_X] = 32'd0;
              nums_d[elp_pkg::N_Y] = 32'd0;
              nums_d[elp_pkg::N_Z] = 32'd0;
            end
          end else if (c == elp_pkg::CH_RBRACE) begin
            mode_d = elp_pkg::MODE_OUT;
            burst_start = 1'b1;
          end
        end
        elp_pkg::MODE_STR: begin
          if (c == elp_pkg::CH_QUOTE) begin
            mode_d = elp_pkg::MODE_IN;
            if (key_q == elp_pkg::KEY_ORIGIN) begin
              if (opart_q == 2'd0) begin
                nums_d[elp_pkg::N_X] = value;
              end else if (opart_q == 2'd1) begin
                nums_d[elp_pkg::N_Z] = 32'd0 - value;
              end else begin
                nums_d[elp_pkg::N_Y] = 32'd0 - value;
              end
            end else if (key_q == elp_pkg::KEY_ANGLE) begin
              nums_d[elp_pkg::N_ANGLE] = value;
            end else if (key_q == elp_pkg::KEY_FLAGS) begin
              nums_d[elp_pkg::N_FLAGS] = value;
            end
            key_d = elp_pkg::KEY_NONE;
            for (int k = 3; k >= 0; k--) begin
              if (flags_q[k] && (pos_q == elp_pkg::KEY_LEN[k])) begin
                key_d = 3'(k);
              end
            end
          end else if (!ended_q) begin
            if (c == elp_pkg::CH_NUL) begin
              ended_d = 1'b1;
            end else begin
              for (int k = 0; k < 4; k++) begin
                if (!(pos_q < elp_pkg::KEY_LEN[k]) ||
                    (elp_pkg::KEY_TEXT[k][pos_q[3:0]] != c)) begin
                  flags_d[k] = 1'b0;
                end
              end
              if (pos_q != 8'd255) begin
                pos_d = pos_q + 8'd1;
              end
              if (key_q == elp_pkg::KEY_CLASS) begin
                if (nlen_q < NameMax) begin
                  ram_we = 1'b1;
                  nlen_d = nlen_q + LenW'(1);
                end
              end else if ((key_q == elp_pkg::KEY_ORIGIN) && (opart_q < 2'd2) &&
                           (c == elp_pkg::CH_SPACE)) begin
                if (opart_q == 2'd0) begin
                  nums_d[elp_pkg::N_X] = value;
                end else begin
                  nums_d[elp_pkg::N_Z] = 32'd0 - value;
                end
                opart_d = opart_q + 2'd1;
                acc_d   = 32'd0;
                phase_d = elp_pkg::PH_SKIP;
              end else if (key_q != elp_pkg::KEY_NONE) begin
                if (phase_q == elp_pkg::PH_SKIP) begin
                  if (!elp_pkg::is_white(c)) begin
                    if (c == elp_pkg::CH_PLUS) begin
                      phase_d = elp_pkg::PH_POS;
                    end else if (c == elp_pkg::CH_MINUS) begin
                      phase_d = elp_pkg::PH_NEG;
                    end else if (elp_pkg::is_digit(c)) begin
                      acc_d   = digit_val;
                      phase_d = elp_pkg::PH_POS;
                    end else begin
                      phase_d = elp_pkg::PH_PDONE;
                    end
                  end
                end else if ((phase_q == elp_pkg::PH_POS) ||
                             (phase_q == elp_pkg::PH_NEG)) begin
                  if (elp_pkg::is_digit(c)) begin
                    acc_d = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} + digit_val;
                  end else begin
                    phase_d = phase_q + 3'd2;
                  end
                end
              end
            end
          end
        end
        default: begin
          if (c == elp_pkg::CH_LBRACE) begin
            mode_d = elp_pkg::MODE_IN;
            nlen_d = '0;
            for (int n = 0; n < elp_pkg::NUM_COUNT; n++) begin
              nums_d[n] = 32'd0;
            end
          end else begin
            mode_d = elp_pkg::MODE_OUT;
          end
        end
      endcase
    end
  end

  assign load    = rd_v_q && (!out_v_q || m_axis_tready);
  assign advance = !rd_v_q || load;
  assign issue   = busy_q && advance;
  assign ram_re  = issue && (idx_q != nlen_q);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    rd_v_d = rd_v_q;
    term_d = term_q;
    if (burst_start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
    if (issue) begin
      rd_v_d = 1'b1;
      term_d = (idx_q == nlen_q);
      idx_d  = idx_q + LenW'(1);
      if (idx_q == nlen_q) begin
        busy_d = 1'b0;
      end
    end else if (advance) begin
      rd_v_d = 1'b0;
    end
  end

  assign name_char = term_q ? 8'd0 : ram_rdata;

  always_comb begin
    out_v_d    = out_v_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (load) begin
      out_v_d    = 1'b1;
      out_data_d = {name_char, nums_q[elp_pkg::N_FLAGS], nums_q[elp_pkg::N_ANGLE],
                    nums_q[elp_pkg::N_Z], nums_q[elp_pkg::N_Y], nums_q[elp_pkg::N_X]};
      out_last_d = term_q;
    end else if (m_axis_tready) begin
      out_v_d = 1'b0;
    end
  end

  elp_ram #(
    .WIDTH (8),
    .DEPTH (NAME_LEN)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (nlen_q[AddrW-1:0]),
    .wdata_i (c),
    .re_i    (ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= elp_pkg::MODE_OUT;
      key_q   <= elp_pkg::KEY_NONE;
      flags_q <= 4'hf;
      pos_q   <= 8'd0;
      nlen_q  <= '0;
      acc_q   <= 32'd0;
      phase_q <= elp_pkg::PH_SKIP;
      opart_q <= 2'd0;
      for (int n = 0; n < elp_pkg::NUM_COUNT; n++) begin
        nums_q[n] <= 32'd0;
      end
      ended_q <= 1'b0;
      busy_q  <= 1'b0;
      idx_q   <= '0;
      rd_v_q  <= 1'b0;
      term_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      key_q   <= key_d;
      flags_q <= flags_d;
      pos_q   <= pos_d;
      nlen_q  <= nlen_d;
      acc_q   <= acc_d;
      phase_q <= phase_d;
      opart_q <= opart_d;
      nums_q  <= nums_d;
      ended_q <= ended_d;
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      rd_v_q  <= rd_v_d;
      term_q  <= term_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
